### rtl/atom_pair_docking_energy_core_assert.svh
// Assertion macros used by the checker file of the docking energy core.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef ATOM_PAIR_DOCKING_ENERGY_CORE_ASSERT_SVH
`define ATOM_PAIR_DOCKING_ENERGY_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APDE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define APDE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/apde_pkg.sv
// Shared types, widths and constant tables of the atom pair docking energy core.
// No dependencies; every module of the core imports this package.
package apde_pkg;

   // Field widths.
   localparam int TYPE_W     = 4;
   localparam int DIST_W     = 16;
   localparam int WEIGHT_W   = 18;
   localparam int GAUSS_W    = 17;
   localparam int REP_W      = 21;
   localparam int RAMP_W     = 17;
   localparam int ENERGY_W   = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 120;

   // Internal widths.
   localparam int D_W    = 22;   // surface distance, signed Q.16
   localparam int MAG_W  = 21;   // magnitude of a surface distance
   localparam int U_W    = 42;   // exponent argument, unsigned Q.30
   localparam int Y_W    = 30;   // scaled exponent argument
   localparam int Q30_W  = 31;   // Q.30 value up to 1.0
   localparam int HBX_W  = 19;   // hydrogen-bond ramp numerator
   localparam int RSUM_W = 19;   // sum of two radii
   localparam int PROD_W = 40;   // weight times term
   localparam int SUM_W  = 43;   // sum of five products

   // Register indexes of the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GAUSS_NEAR  = 3'd0,
      CSR_GAUSS_FAR   = 3'd1,
      CSR_REPULSION   = 3'd2,
      CSR_HYDROPHOBIC = 3'd3,
      CSR_HBOND       = 3'd4
   } csr_index_type;

   typedef logic signed [WEIGHT_W-1:0] weight_type;

   typedef struct packed {
      weight_type gauss_near;
      weight_type gauss_far;
      weight_type repulsion;
      weight_type hydrophobic;
      weight_type hbond;
   } weights_type;

   localparam weight_type RST_GAUSS_NEAR  = -18'sd2332;
   localparam weight_type RST_GAUSS_FAR   = -18'sd338;
   localparam weight_type RST_REPULSION   = 18'sd55066;
   localparam weight_type RST_HYDROPHOBIC = -18'sd2298;
   localparam weight_type RST_HBOND       = -18'sd38499;

   // Atom type classes, one bit per type code.
   localparam logic [TYPE_W-1:0] TYPE_INVALID = 4'd15;
   localparam logic [15:0] HYDRO_SET  = 16'h3C01;
   localparam logic [15:0] DONOR_SET  = 16'h40A8;
   localparam logic [15:0] ACCEPT_SET = 16'h00F0;

   // Van der Waals radii in Q.16, indexed by type code.
   localparam logic [WEIGHT_W-1:0] RADIUS_Q16 [16] = '{
      18'd124518, 18'd124518, 18'd117965, 18'd117965,
      18'd117965, 18'd117965, 18'd111411, 18'd111411,
      18'd131072, 18'd137626, 18'd98304,  18'd117965,
      18'd131072, 18'd144179, 18'd78643,  18'd0
   };

   // Ramp and Gaussian break points in Q.16.
   localparam logic signed [D_W-1:0] HYD_HI      = 22'sd98304;
   localparam logic signed [D_W-1:0] HYD_LO      = 22'sd32768;
   localparam logic signed [D_W-1:0] HB_LO       = -22'sd45875;
   localparam logic signed [D_W-1:0] FAR_CENTER  = 22'sd196608;
   localparam logic [RAMP_W-1:0]     RAMP_ONE    = 17'd65536;
   localparam int                    HB_DIV      = 7;

   // Exponential unit.
   localparam int HORNER_STEPS = 10;
   localparam int SQUARE_STEPS = 4;
   localparam logic [U_W-1:0]   EXP_LIMIT = U_W'(12) << 30;
   localparam logic [Q30_W-1:0] Q30_ONE   = Q30_W'(1) << 30;

   // floor(2^32 / n) for the constant divisors 1 to 10.
   localparam logic [32:0] RECIP_Q32 [1:10] = '{
      33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
      33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
      33'd477218588,  33'd429496729
   };

   // Pipeline depths.
   localparam int FRONT_LAT  = 4;
   localparam int EXP_LAT    = 1 + 3 * HORNER_STEPS + SQUARE_STEPS + 1;
   localparam int ENERGY_LAT = 4;
   localparam int CORE_LAT   = FRONT_LAT + EXP_LAT + ENERGY_LAT;

   // Terms that bypass the exponential units.
   typedef struct packed {
      logic [REP_W-1:0]  repulsion;
      logic [RAMP_W-1:0] hydrophobic;
      logic [RAMP_W-1:0] hbond;
      logic              invalid_type;
   } side_type;

   // Every unweighted term plus the flag.
   typedef struct packed {
      logic [GAUSS_W-1:0] gauss_near;
      logic [GAUSS_W-1:0] gauss_far;
      logic [REP_W-1:0]   repulsion;
      logic [RAMP_W-1:0]  hydrophobic;
      logic [RAMP_W-1:0]  hbond;
      logic               invalid_type;
   } terms_type;

   // One complete result item.
   typedef struct packed {
      logic signed [ENERGY_W-1:0] energy;
      terms_type                  terms;
   } result_type;

endpackage

### rtl/atom_pair_docking_energy_core.sv
// Top level of the atom pair docking energy core: weight registers, valid line,
// front stages, two exponential units, weighted sum and output buffer. Uses apde_pkg.
//
//   Channel | Direction | Transfer content
//   req_    | in        | tdata: type_a[3:0], type_b[7:4], distance[23:8]
//   rsp_    | out       | tdata: energy, five terms; tuser: invalid_type
//   csr_    | in        | write of one Q1.16 weight per register index
//
// One item per clock cycle is accepted while req_tready is high; each result passes
// 4 front stages, 36 in the exponential units, 4 in the weighted sum and 1 in the
// output buffer before it is offered.
// Synchronous active-high reset clears valid bits and loads the default weights.
// A two-entry output buffer absorbs result stalls; the pipeline stops only when
// it is full, and req_tready then drops for as long as the stall lasts.
module atom_pair_docking_energy_core import apde_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,    // type_a, type_b, distance
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // energy, gauss_near, gauss_far,
                                               // repulsion, hydrophobic, hbond, zero pad
   output logic                  rsp_tuser,    // invalid_type
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [WEIGHT_W-1:0]   csr_wdata
);

   weights_type weights_ff, weights_in;
   logic [CORE_LAT-1:0] vld_ff, vld_in;
   side_type side_dly_ff [EXP_LAT], side_dly_in [EXP_LAT];
   logic enable, fifo_full, push;
   logic [U_W-1:0] u_near, u_far;
   logic [GAUSS_W-1:0] g_near, g_far;
   side_type side_front, side_late;
   terms_type terms;
   result_type core_res, out_res;

   // Weight registers.
   always_comb begin
      weights_in = weights_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_GAUSS_NEAR:  weights_in.gauss_near  = csr_wdata;
            CSR_GAUSS_FAR:   weights_in.gauss_far   = csr_wdata;
            CSR_REPULSION:   weights_in.repulsion   = csr_wdata;
            CSR_HYDROPHOBIC: weights_in.hydrophobic = csr_wdata;
            CSR_HBOND:       weights_in.hbond       = csr_wdata;
            default:         weights_in = weights_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff.gauss_near  <= RST_GAUSS_NEAR;
         weights_ff.gauss_far   <= RST_GAUSS_FAR;
         weights_ff.repulsion   <= RST_REPULSION;
         weights_ff.hydrophobic <= RST_HYDROPHOBIC;
         weights_ff.hbond       <= RST_HBOND;
      end else begin
         weights_ff <= weights_in;
      end
   end

   // The whole pipeline moves together while the output buffer has room.
   assign enable     = !fifo_full;
   assign req_tready = enable;
   assign vld_in     = {vld_ff[CORE_LAT-2:0], req_tvalid};
   assign push       = vld_ff[CORE_LAT-1] && enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   apde_front u_front (
      .clock    (clock),
      .enable   (enable),
      .type_a   (req_tdata[3:0]),
      .type_b   (req_tdata[7:4]),
      .distance (req_tdata[23:8]),
      .u_near   (u_near),
      .u_far    (u_far),
      .side     (side_front)
   );

   apde_exp_pipe u_exp_near (
      .clock  (clock),
      .enable (enable),
      .u      (u_near),
      .result (g_near)
   );

   apde_exp_pipe u_exp_far (
      .clock  (clock),
      .enable (enable),
      .u      (u_far),
      .result (g_far)
   );

   // Delay line that keeps the bypass terms aligned with the exponential units.
   for (genvar i = 0; i < EXP_LAT; i++) begin : g_side
      if (i == 0) begin : g_first
         assign side_dly_in[i] = side_front;
      end else begin : g_next
         assign side_dly_in[i] = side_dly_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            side_dly_ff[i] <= side_dly_in[i];
         end
      end
   end

   assign side_late = side_dly_ff[EXP_LAT-1];

   // An invalid type zeroes both Gaussians; the other terms are already zero.
   always_comb begin
      terms.gauss_near   = side_late.invalid_type ? '0 : g_near;
      terms.gauss_far    = side_late.invalid_type ? '0 : g_far;
      terms.repulsion    = side_late.repulsion;
      terms.hydrophobic  = side_late.hydrophobic;
      terms.hbond        = side_late.hbond;
      terms.invalid_type = side_late.invalid_type;
   end

   apde_energy u_energy (
      .clock   (clock),
      .enable  (enable),
      .weights (weights_ff),
      .terms   (terms),
      .result  (core_res)
   );

   apde_out_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .din       (core_res),
      .full      (fifo_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .dout      (out_res)
   );

   assign rsp_tdata = {7'b0000000, out_res.terms.hbond, out_res.terms.hydrophobic,
                       out_res.terms.repulsion, out_res.terms.gauss_far,
                       out_res.terms.gauss_near, out_res.energy};
   assign rsp_tuser = out_res.terms.invalid_type;

endmodule

### rtl/apde_front.sv
// Front stages: radius lookup, surface distance, ramps, repulsion and the
// squared exponent arguments of both Gaussians. Uses apde_pkg.
module apde_front import apde_pkg::*; (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [TYPE_W-1:0]    type_a,
   input  logic [TYPE_W-1:0]    type_b,
   input  logic [DIST_W-1:0]    distance,
   output logic [U_W-1:0]       u_near,
   output logic [U_W-1:0]       u_far,
   output side_type             side
);

   typedef enum logic [1:0] {HB_ZERO, HB_FULL, HB_RAMP} hb_mode_type;

   // Stage 1 registers.
   logic signed [D_W-1:0] d1_ff, d1_in;
   logic inv1_ff, inv1_in, hyd_pair1_ff, hyd_pair1_in, hb_pair1_ff, hb_pair1_in;
   logic [RSUM_W-1:0] rad_sum;

   // Stage 2 registers.
   logic [MAG_W-1:0] magn2_ff, magn2_in, magf2_ff, magf2_in;
   logic neg2_ff, neg2_in, inv2_ff, inv2_in;
   logic [RAMP_W-1:0] hyd2_ff, hyd2_in;
   hb_mode_type hbm2_ff, hbm2_in;
   logic [HBX_W-1:0] hbx2_ff, hbx2_in;
   logic signed [D_W-1:0] far1, ndist1;

   // Stage 3 registers.
   logic [U_W-1:0] un3_ff, un3_in, uf3_ff, uf3_in;
   logic [REP_W-1:0] rep3_ff, rep3_in;
   logic [RAMP_W-1:0] hyd3_ff, hyd3_in;
   hb_mode_type hbm3_ff, hbm3_in;
   logic [HBX_W-1:0] hbx3_ff, hbx3_in, hbq3_ff, hbq3_in;
   logic inv3_ff, inv3_in;
   logic [2*MAG_W-1:0] sqn2, sqf2;
   logic [HBX_W+32:0] hb_prod;

   // Stage 4 registers.
   logic [U_W-1:0] un4_ff, un4_in, uf4_ff, uf4_in;
   side_type side4_ff, side4_in;
   logic [HBX_W-1:0] hb_rem;
   logic [RAMP_W-1:0] hb_val;

   // Stage 1: surface distance and pair classes.
   always_comb begin
      rad_sum      = {1'b0, RADIUS_Q16[type_a]} + {1'b0, RADIUS_Q16[type_b]};
      d1_in        = $signed({2'b00, distance, 4'b0000}) - $signed({3'b000, rad_sum});
      inv1_in      = (type_a == TYPE_INVALID) || (type_b == TYPE_INVALID);
      hyd_pair1_in = HYDRO_SET[type_a] && HYDRO_SET[type_b];
      hb_pair1_in  = (DONOR_SET[type_a] && ACCEPT_SET[type_b]) ||
                     (DONOR_SET[type_b] && ACCEPT_SET[type_a]);
   end

   // Stage 2: magnitudes, hydrophobic ramp and the hydrogen-bond numerator.
   always_comb begin
      far1     = d1_ff - FAR_CENTER;
      ndist1   = -d1_ff;
      magn2_in = (d1_ff < 0) ? MAG_W'(ndist1) : MAG_W'(d1_ff);
      magf2_in = (far1 < 0) ? MAG_W'(-far1) : MAG_W'(far1);
      neg2_in  = (d1_ff < 0);
      inv2_in  = inv1_ff;
      if (!hyd_pair1_ff || inv1_ff || d1_ff >= HYD_HI) begin
         hyd2_in = '0;
      end else if (d1_ff <= HYD_LO) begin
         hyd2_in = RAMP_ONE;
      end else begin
         hyd2_in = RAMP_W'(HYD_HI - d1_ff);
      end
      if (!hb_pair1_ff || inv1_ff || d1_ff >= 0) begin
         hbm2_in = HB_ZERO;
      end else if (d1_ff <= HB_LO) begin
         hbm2_in = HB_FULL;
      end else begin
         hbm2_in = HB_RAMP;
      end
      hbx2_in = HBX_W'(ndist1 * 10 + 3);
   end

   // Stage 3: squares, repulsion and the reciprocal estimate for the divide by seven.
   always_comb begin
      sqn2    = magn2_ff * magn2_ff;
      sqf2    = magf2_ff * magf2_ff;
      hb_prod = hbx2_ff * RECIP_Q32[HB_DIV];
      un3_in  = U_W'(sqn2);
      uf3_in  = U_W'(sqf2 >> 4);
      rep3_in = (neg2_ff && !inv2_ff) ? REP_W'((sqn2 + (2*MAG_W)'(32768)) >> 16) : '0;
      hyd3_in = hyd2_ff;
      hbm3_in = hbm2_ff;
      hbx3_in = hbx2_ff;
      hbq3_in = HBX_W'(hb_prod >> 32);
      inv3_in = inv2_ff;
   end

   // Stage 4: quotient correction and the hydrogen-bond term.
   always_comb begin
      hb_rem = hbx3_ff - HBX_W'(hbq3_ff * HBX_W'(HB_DIV));
      hb_val = (hb_rem >= HBX_W'(HB_DIV)) ? RAMP_W'(hbq3_ff + 1'b1) : RAMP_W'(hbq3_ff);
      un4_in = un3_ff;
      uf4_in = uf3_ff;
      side4_in.repulsion    = rep3_ff;
      side4_in.hydrophobic  = hyd3_ff;
      side4_in.invalid_type = inv3_ff;
      case (hbm3_ff)
         HB_FULL: side4_in.hbond = RAMP_ONE;
         HB_RAMP: side4_in.hbond = hb_val;
         default: side4_in.hbond = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d1_ff        <= d1_in;
         inv1_ff      <= inv1_in;
         hyd_pair1_ff <= hyd_pair1_in;
         hb_pair1_ff  <= hb_pair1_in;
         magn2_ff     <= magn2_in;
         magf2_ff     <= magf2_in;
         neg2_ff      <= neg2_in;
         inv2_ff      <= inv2_in;
         hyd2_ff      <= hyd2_in;
         hbm2_ff      <= hbm2_in;
         hbx2_ff      <= hbx2_in;
         un3_ff       <= un3_in;
         uf3_ff       <= uf3_in;
         rep3_ff      <= rep3_in;
         hyd3_ff      <= hyd3_in;
         hbm3_ff      <= hbm3_in;
         hbx3_ff      <= hbx3_in;
         hbq3_ff      <= hbq3_in;
         inv3_ff      <= inv3_in;
         un4_ff       <= un4_in;
         uf4_ff       <= uf4_in;
         side4_ff     <= side4_in;
      end
   end

   assign u_near = un4_ff;
   assign u_far  = uf4_ff;
   assign side   = side4_ff;

endmodule

### rtl/apde_exp_pipe.sv
// Pipelined exp(-u): a degree ten Horner series on u/16 followed by four squarings.
// Each Horner step takes three stages (multiply, reciprocal, correction). Uses apde_pkg.
module apde_exp_pipe import apde_pkg::*; (
   input  logic               clock,
   input  logic               enable,
   input  logic [U_W-1:0]     u,
   output logic [GAUSS_W-1:0] result
);

   // Entry stage.
   logic [Y_W-1:0] y0_ff, y0_in;
   logic z0_ff, z0_in;

   // Horner stages: m = product, q = reciprocal estimate, c = corrected step.
   logic [Y_W-1:0]   y_m_ff [HORNER_STEPS], y_q_ff [HORNER_STEPS], y_c_ff [HORNER_STEPS];
   logic             z_m_ff [HORNER_STEPS], z_q_ff [HORNER_STEPS], z_c_ff [HORNER_STEPS];
   logic [Y_W-1:0]   p_m_ff [HORNER_STEPS], p_m_in [HORNER_STEPS];
   logic [Y_W-1:0]   p_q_ff [HORNER_STEPS];
   logic [Y_W-1:0]   q_q_ff [HORNER_STEPS], q_q_in [HORNER_STEPS];
   logic [Q30_W-1:0] t_c_ff [HORNER_STEPS], t_c_in [HORNER_STEPS];

   // Squaring stages.
   logic [Q30_W-1:0] sq_ff [SQUARE_STEPS], sq_in [SQUARE_STEPS];
   logic             z_s_ff [SQUARE_STEPS];

   // Output stage.
   logic [GAUSS_W-1:0] res_ff, res_in;

   // Entry: range check and scaling by 1/16.
   assign z0_in = (u >= EXP_LIMIT);
   assign y0_in = u[Y_W+3:4];

   always_ff @(posedge clock) begin
      if (enable) begin
         y0_ff <= y0_in;
         z0_ff <= z0_in;
      end
   end

   for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
      localparam int N = HORNER_STEPS - k;
      logic [Y_W-1:0]     y_src;
      logic               z_src;
      logic [Q30_W-1:0]   t_src;
      logic [2*Q30_W-1:0] prod_m;
      logic [Y_W+32:0]    prod_q;
      logic [Y_W-1:0]     rem;
      logic [Y_W-1:0]     q_fix;

      if (k == 0) begin : g_first
         assign y_src = y0_ff;
         assign z_src = z0_ff;
         assign t_src = Q30_ONE;
      end else begin : g_next
         assign y_src = y_c_ff[k-1];
         assign z_src = z_c_ff[k-1];
         assign t_src = t_c_ff[k-1];
      end

      // Product y*t in Q.30.
      assign prod_m    = {1'b0, y_src} * t_src;
      assign p_m_in[k] = Y_W'(prod_m >> 30);

      // Quotient estimate, low by at most one.
      assign prod_q    = p_m_ff[k] * RECIP_Q32[N];
      assign q_q_in[k] = Y_W'(prod_q >> 32);

      // Correction and the next Horner value.
      assign rem       = p_q_ff[k] - Y_W'(q_q_ff[k] * Y_W'(N));
      assign q_fix     = (rem >= Y_W'(N)) ? Y_W'(q_q_ff[k] + 1'b1) : q_q_ff[k];
      assign t_c_in[k] = Q30_ONE - {1'b0, q_fix};

      always_ff @(posedge clock) begin
         if (enable) begin
            y_m_ff[k] <= y_src;
            z_m_ff[k] <= z_src;
            p_m_ff[k] <= p_m_in[k];
            y_q_ff[k] <= y_m_ff[k];
            z_q_ff[k] <= z_m_ff[k];
            p_q_ff[k] <= p_m_ff[k];
            q_q_ff[k] <= q_q_in[k];
            y_c_ff[k] <= y_q_ff[k];
            z_c_ff[k] <= z_q_ff[k];
            t_c_ff[k] <= t_c_in[k];
         end
      end
   end

   for (genvar k = 0; k < SQUARE_STEPS; k++) begin : g_square
      logic [Q30_W-1:0]   s_src;
      logic               zs_src;
      logic [2*Q30_W-1:0] prod_s;

      if (k == 0) begin : g_first
         assign s_src  = t_c_ff[HORNER_STEPS-1];
         assign zs_src = z_c_ff[HORNER_STEPS-1];
      end else begin : g_next
         assign s_src  = sq_ff[k-1];
         assign zs_src = z_s_ff[k-1];
      end

      // Rounded square in Q.30.
      assign prod_s   = s_src * s_src;
      assign sq_in[k] = Q30_W'((prod_s + (2*Q30_W)'(1 << 29)) >> 30);

      always_ff @(posedge clock) begin
         if (enable) begin
            sq_ff[k]  <= sq_in[k];
            z_s_ff[k] <= zs_src;
         end
      end
   end

   // Round Q.30 down to Q.16; arguments past the limit give zero.
   assign res_in = z_s_ff[SQUARE_STEPS-1] ? '0 :
                   GAUSS_W'((sq_ff[SQUARE_STEPS-1] + Q30_W'(1 << 13)) >> 14);

   always_ff @(posedge clock) begin
      if (enable) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

### rtl/apde_energy.sv
// Weighted sum of the five terms: products, two addition stages, then rounding
// and saturation to signed Q7.16. Uses apde_pkg.
module apde_energy import apde_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  weights_type weights,
   input  terms_type   terms,
   output result_type  result
);

   localparam logic signed [SUM_W-1:0] E_MAX = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0] E_MIN = -SUM_W'(8388608);
   localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(32768);

   // Stage 1: products.
   logic signed [PROD_W-1:0] p_ff [5], p_in [5];
   terms_type t1_ff;

   // Stage 2: partial sums.
   logic signed [SUM_W-1:0] sa_ff, sa_in, sb_ff, sb_in, sc_ff, sc_in;
   terms_type t2_ff;

   // Stage 3: total.
   logic signed [SUM_W-1:0] tot_ff, tot_in;
   terms_type t3_ff;

   // Stage 4: rounded and saturated energy.
   result_type res_ff, res_in;
   logic signed [SUM_W-1:0] rnd;

   always_comb begin
      p_in[0] = weights.gauss_near  * $signed({1'b0, terms.gauss_near});
      p_in[1] = weights.gauss_far   * $signed({1'b0, terms.gauss_far});
      p_in[2] = weights.repulsion   * $signed({1'b0, terms.repulsion});
      p_in[3] = weights.hydrophobic * $signed({1'b0, terms.hydrophobic});
      p_in[4] = weights.hbond       * $signed({1'b0, terms.hbond});
   end

   always_comb begin
      sa_in  = SUM_W'(p_ff[0]) + SUM_W'(p_ff[1]);
      sb_in  = SUM_W'(p_ff[2]) + SUM_W'(p_ff[3]);
      sc_in  = SUM_W'(p_ff[4]);
      tot_in = sa_ff + sb_ff + sc_ff;
   end

   // Round half up to Q.16 and clamp to the output range.
   always_comb begin
      rnd          = (tot_ff + HALF) >>> 16;
      res_in.terms = t3_ff;
      if (rnd > E_MAX) begin
         res_in.energy = ENERGY_W'(E_MAX);
      end else if (rnd < E_MIN) begin
         res_in.energy = ENERGY_W'(E_MIN);
      end else begin
         res_in.energy = ENERGY_W'(rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff   <= p_in;
         t1_ff  <= terms;
         sa_ff  <= sa_in;
         sb_ff  <= sb_in;
         sc_ff  <= sc_in;
         t2_ff  <= t1_ff;
         tot_ff <= tot_in;
         t3_ff  <= t2_ff;
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

### rtl/apde_out_skid.sv
// Two-entry output buffer between the core pipeline and the result channel.
// Full is taken from a register only, so the input side never waits on rsp_tready.
module apde_out_skid import apde_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type din,
   output logic       full,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type dout
);

   logic [1:0] cnt_ff, cnt_in;
   result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic pop;

   assign pop = out_valid && out_ready;

   // Slot 0 always holds the oldest item.
   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               slot0_in = din;
               cnt_in   = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               slot0_in = din;
            end else if (push) begin
               slot1_in = din;
               cnt_in   = 2'd2;
            end else if (pop) begin
               cnt_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               slot0_in = slot1_ff;
               cnt_in   = 2'd1;
            end
         end
         default: cnt_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full      = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign dout      = slot0_ff;

endmodule

### rtl/apde_checker.sv
// Port-level checker for the docking energy core, attached by the bind below.
// Uses apde_pkg and the assertion macros of atom_pair_docking_energy_core_assert.svh.
`include "atom_pair_docking_energy_core_assert.svh"

module apde_checker import apde_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  csr_we,
   input logic [CSR_ADDR_W-1:0] csr_addr,
   input logic [WEIGHT_W-1:0]   csr_wdata
);

   // A stalled result stays offered and unchanged.
   `APDE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp_tvalid dropped")
   `APDE_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp_tdata moved")

   // An invalid type code yields an all-zero payload.
   `APDE_ASSERT_SAME(a_invalid_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "invalid not zeroed")

   // Both Gaussian terms stay at or below one in Q1.16.
   `APDE_ASSERT_SAME(a_gauss_range, rsp_tvalid, (rsp_tdata[40:24] <= 17'd65536) && (rsp_tdata[57:41] <= 17'd65536), "Gaussian above one")

endmodule

bind atom_pair_docking_energy_core apde_checker u_apde_checker (.*);
